// ===== sv/llpe_pkg.sv =====
// Shared types and constants for the linked-list position engine.
`default_nettype none
package llpe_pkg;
	localparam int CAPACITY_DEF    = 256;
	localparam int VALUE_WIDTH_DEF = 32;
	localparam int OP_W            = 3;
	localparam int POS_W           = 9;
	localparam int IN_VALUE_W      = 32;
	localparam int STATUS_W        = 2;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR  = 3'd0,
		OP_INSERT = 3'd1,
		OP_DELETE = 3'd2,
		OP_READ   = 3'd3,
		OP_LOCATE = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_BAD_POS   = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_CLEAR,
		S_FREE_SCAN,
		S_WALK,
		S_WALK_WAIT,
		S_LINK,
		S_LINK_WAIT,
		S_FINISH,
		S_LOC_READ,
		S_LOC_WAIT,
		S_LOC_CMP,
		S_RESULT
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;        // capture the incoming word
		logic clear;       // clearing command (unused; clr_start resets the free map and list)
		logic clr_start;
		logic scan_start;
		logic scan_step;
		logic walk_start;  // start at first node
		logic rd_issue;    // read current node
		logic walk_step;   // advance to next node
		logic do_insert;
		logic do_delete;
		logic set_ok;
		logic set_bad;
		logic set_full;
		logic set_nf;
		logic set_found;
		logic set_item;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		op_t  op;
		logic pos_bad;
		logic pool_full;
		logic clr_done;
		logic scan_hit;
		logic scan_done;
		logic walk_done;   // step counter reached target
		logic at_end;      // locate ran past the list
		logic match;
		logic out_busy;
	} dp_stat_t;
endpackage
`default_nettype wire

// ===== sv/llpe_datapath.sv =====
// Datapath: node stores, free map, walk pointer, counters and result register.
`default_nettype none
module llpe_datapath #(
	parameter int CAPACITY    = llpe_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = llpe_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire llpe_pkg::dp_cmd_t                 cmd,
	output llpe_pkg::dp_stat_t                     stat,
	input  wire logic [llpe_pkg::OP_W-1:0]         operation,
	input  wire logic [llpe_pkg::POS_W-1:0]        position,
	input  wire logic signed [llpe_pkg::IN_VALUE_W-1:0] value,
	input  wire logic                              out_take,
	output logic [llpe_pkg::STATUS_W-1:0]          status,
	output logic signed [llpe_pkg::IN_VALUE_W-1:0] item_value,
	output logic [llpe_pkg::POS_W-1:0]             found_position,
	output logic [llpe_pkg::POS_W-1:0]             list_length,
	output logic                                   is_empty
);
	import llpe_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int PW = IW + 1;   // index with null
	localparam int CW = IW + 1;   // count up to CAPACITY
	localparam logic [PW-1:0] NUL = PW'(CAPACITY);

	// node stores, one write and one read port each
	logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
	logic [PW-1:0]          lnk_mem [CAPACITY];
	logic [VALUE_WIDTH-1:0] val_rd;
	logic [PW-1:0]          lnk_rd;

	logic [CAPACITY-1:0] free_q;
	logic [PW-1:0] first_q, cur_q, prev_q, slot_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] scan_q;
	logic          scan_end_q;
	logic [CW-1:0] step_q;
	op_t           op_q;
	logic [POS_W-1:0] pos_q;
	logic [VALUE_WIDTH-1:0] v_q;
	status_t       st_q;
	logic [VALUE_WIDTH-1:0] item_q;
	logic [CW-1:0] found_q;
	logic          obusy_q;
	logic          relink_q;
	status_t       o_st_q;
	logic [IN_VALUE_W-1:0] o_item_q;
	logic [POS_W-1:0] o_found_q, o_len_q;
	logic          o_empty_q;

	logic [POS_W:0] cnt_x;
	logic [PW-1:0]  rd_addr;
	logic [IW-1:0]  rd_idx;
	logic           del_first;
	logic [CW-1:0]  target;

	assign cnt_x = (POS_W+1)'(count_q);
	// walk target: predecessor for insert, the node itself for read and delete
	assign target = (op_q == OP_INSERT) ? CW'(pos_q) - CW'(2) : CW'(pos_q) - CW'(1);
	assign del_first = (pos_q == POS_W'(1));
	assign rd_addr = cur_q;
	assign rd_idx  = rd_addr[IW-1:0];

	// synchronous read port
	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			val_rd <= val_mem[rd_idx];
			lnk_rd <= lnk_mem[rd_idx];
		end
	end

	// predecessor relink on insert follows in the cycle after the new node is written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) relink_q <= 1'b0;
		else         relink_q <= cmd.do_insert && (pos_q != POS_W'(1));
	end

	// write port: new node on insert, then predecessor relink; bypass on delete
	always_ff @(posedge clk) begin
		if (cmd.do_insert) begin
			val_mem[slot_q[IW-1:0]] <= v_q;
			lnk_mem[slot_q[IW-1:0]] <= (pos_q == POS_W'(1)) ? first_q : lnk_rd;
		end else if (relink_q) begin
			lnk_mem[prev_q[IW-1:0]] <= slot_q;
		end else if (cmd.do_delete && !del_first) begin
			lnk_mem[prev_q[IW-1:0]] <= lnk_rd;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q     <= '1;
			first_q    <= NUL;
			count_q    <= '0;
			cur_q      <= NUL;
			prev_q     <= NUL;
			slot_q     <= NUL;
			scan_q     <= '0;
			scan_end_q <= 1'b0;
			step_q     <= '0;
			obusy_q    <= 1'b0;
			op_q       <= OP_CLEAR;
			pos_q      <= '0;
			v_q        <= '0;
			st_q       <= ST_OK;
			item_q     <= '0;
			found_q    <= '0;
		end else begin
			if (cmd.load) begin
				op_q  <= op_t'(operation);
				pos_q <= position;
				v_q   <= VALUE_WIDTH'(value);
				st_q  <= ST_OK;
				item_q  <= '0;
				found_q <= '0;
			end
			if (cmd.clr_start) begin
				free_q  <= '1;
				first_q <= NUL;
				count_q <= '0;
			end
			if (cmd.scan_start) begin
				scan_q     <= '0;
				scan_end_q <= 1'b0;
			end else if (cmd.scan_step) begin
				if (free_q[scan_q]) slot_q <= PW'(scan_q);
				else begin
					if (scan_q == IW'(CAPACITY-1)) scan_end_q <= 1'b1;
					else scan_q <= scan_q + IW'(1);
				end
			end
			if (cmd.walk_start) begin
				cur_q  <= first_q;
				prev_q <= NUL;
				step_q <= '0;
			end else if (cmd.walk_step) begin
				prev_q <= cur_q;
				cur_q  <= lnk_rd;
				step_q <= step_q + CW'(1);
			end
			if (cmd.do_insert) begin
				free_q[slot_q[IW-1:0]] <= 1'b0;
				if (pos_q == POS_W'(1)) first_q <= slot_q;
				prev_q  <= cur_q;
				count_q <= count_q + CW'(1);
			end
			if (cmd.do_delete) begin
				// cur_q points at the node removed; lnk_rd holds its link
				free_q[cur_q[IW-1:0]] <= 1'b1;
				if (del_first) first_q <= lnk_rd;
				count_q <= count_q - CW'(1);
			end
			if (cmd.set_bad)   st_q <= ST_BAD_POS;
			if (cmd.set_full)  st_q <= ST_FULL;
			if (cmd.set_nf)    st_q <= ST_NOT_FOUND;
			if (cmd.set_ok)    st_q <= ST_OK;
			if (cmd.set_found) found_q <= step_q + CW'(1);
			if (cmd.set_item)  item_q <= val_rd;
			if (cmd.out_load)  obusy_q <= 1'b1;
			else if (out_take) obusy_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			o_st_q    <= st_q;
			o_item_q  <= IN_VALUE_W'(signed'(item_q));
			o_found_q <= POS_W'(found_q);
			o_len_q   <= POS_W'(count_q);
			o_empty_q <= (count_q == '0);
		end
	end

	// status to controller
	always_comb begin
		stat.op        = op_q;
		stat.pos_bad   = 1'b0;
		unique case (op_q)
			OP_INSERT: stat.pos_bad = (pos_q == '0) || ((POS_W+1)'(pos_q) > cnt_x + 1'b1);
			OP_DELETE, OP_READ: stat.pos_bad = (pos_q == '0) || ((POS_W+1)'(pos_q) > cnt_x);
			default:   stat.pos_bad = 1'b0;
		endcase
		stat.pool_full = (count_q >= CW'(CAPACITY));
		stat.clr_done  = 1'b1;
		stat.scan_hit  = free_q[scan_q];
		stat.scan_done = scan_end_q;
		// insert at the head needs no predecessor
		stat.walk_done = (step_q == target) || ((op_q == OP_INSERT) && del_first);
		stat.at_end    = (cur_q == NUL) || (step_q >= count_q);
		stat.match     = (val_rd == v_q);
		stat.out_busy  = obusy_q;
	end

	assign status         = o_st_q;
	assign item_value     = o_item_q;
	assign found_position = o_found_q;
	assign list_length    = o_len_q;
	assign is_empty       = o_empty_q;
endmodule
`default_nettype wire

// ===== sv/llpe_ctrl.sv =====
// Controller state machine sequencing each operation over the datapath.
`default_nettype none
module llpe_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire llpe_pkg::dp_stat_t stat,
	output llpe_pkg::dp_cmd_t       cmd
);
	import llpe_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid) state_d = S_DECODE;
			S_DECODE: begin
				unique case (stat.op)
					OP_CLEAR:  state_d = S_RESULT;
					OP_INSERT: state_d = (stat.pos_bad || stat.pool_full) ? S_RESULT : S_FREE_SCAN;
					OP_DELETE, OP_READ: state_d = stat.pos_bad ? S_RESULT : S_WALK;
					OP_LOCATE: state_d = S_LOC_READ;
					default:   state_d = S_RESULT;
				endcase
			end
			S_FREE_SCAN: if (stat.scan_hit) state_d = S_WALK;
				else if (stat.scan_done) state_d = S_RESULT;
			S_WALK:      state_d = S_WALK_WAIT;
			S_WALK_WAIT: state_d = stat.walk_done ? S_LINK : S_WALK;
			S_LINK:      state_d = S_LINK_WAIT;
			S_LINK_WAIT: state_d = S_FINISH;
			S_FINISH:    state_d = S_RESULT;
			S_LOC_READ:  state_d = stat.at_end ? S_RESULT : S_LOC_WAIT;
			S_LOC_WAIT:  state_d = S_LOC_CMP;
			S_LOC_CMP:   state_d = stat.match ? S_RESULT : S_LOC_READ;
			S_RESULT:    if (!stat.out_busy) state_d = S_IDLE;
			S_CLEAR:     state_d = S_RESULT;
			default:     state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: cmd.load = in_valid;
			S_DECODE: begin
				unique case (stat.op)
					OP_CLEAR:  cmd.clr_start = 1'b1;
					OP_INSERT: begin
						cmd.set_bad  = stat.pos_bad;
						cmd.set_full = !stat.pos_bad && stat.pool_full;
						cmd.scan_start = 1'b1;
						cmd.walk_start = 1'b1;
					end
					OP_DELETE, OP_READ: begin
						cmd.set_bad = stat.pos_bad;
						cmd.walk_start = 1'b1;
					end
					OP_LOCATE: cmd.walk_start = 1'b1;
					default: ;
				endcase
			end
			S_FREE_SCAN: begin
				cmd.scan_step = 1'b1;
				cmd.set_full  = !stat.scan_hit && stat.scan_done;
			end
			S_WALK: cmd.rd_issue = 1'b1;
			S_WALK_WAIT: cmd.walk_step = !stat.walk_done;
			// read the node at the stop point (predecessor or target)
			S_LINK: cmd.rd_issue = 1'b1;
			S_LINK_WAIT: ;
			S_FINISH: begin
				unique case (stat.op)
					OP_INSERT: cmd.do_insert = 1'b1;
					OP_DELETE: begin
						cmd.do_delete = 1'b1;
						cmd.set_item  = 1'b1;
					end
					OP_READ:   cmd.set_item  = 1'b1;
					default:   ;
				endcase
			end
			S_LOC_READ: begin
				cmd.rd_issue = !stat.at_end;
				cmd.set_nf   = stat.at_end;
			end
			S_LOC_CMP: begin
				cmd.set_found = stat.match;
				cmd.walk_step = !stat.match;
			end
			S_RESULT: cmd.out_load = !stat.out_busy;
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/linked_list_position_engine.sv =====
// Top level of the linked-list position engine.
`default_nettype none
// An ordered list of signed values in a pool of CAPACITY nodes, one
// operation per word: clear, insert, delete, read at a 1-based position,
// or locate a value. Positional operations walk the link chain through the
// single node store read port, reading each node and then stepping to its
// link. Insert first scans the free map one node a cycle from node 0 up to
// the lowest free node, then walks to the predecessor. Locate reads, waits
// on and compares each node in turn until a match or the end of the list.
// One result word per input word, held in an output register.
module linked_list_position_engine #(
	parameter int CAPACITY    = llpe_pkg::CAPACITY_DEF,
	parameter int VALUE_WIDTH = llpe_pkg::VALUE_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [llpe_pkg::OP_W-1:0]         operation,
	input  wire logic [llpe_pkg::POS_W-1:0]        position,
	input  wire logic signed [llpe_pkg::IN_VALUE_W-1:0] value,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [llpe_pkg::STATUS_W-1:0]          status,
	output logic signed [llpe_pkg::IN_VALUE_W-1:0] item_value,
	output logic [llpe_pkg::POS_W-1:0]             found_position,
	output logic [llpe_pkg::POS_W-1:0]             list_length,
	output logic                                   is_empty
);
	import llpe_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	llpe_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.stat(stat), .cmd(cmd)
	);

	llpe_datapath #(.CAPACITY(CAPACITY), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.operation(operation), .position(position), .value(value),
		.out_take(out_valid && out_ready),
		.status(status), .item_value(item_value), .found_position(found_position),
		.list_length(list_length), .is_empty(is_empty)
	);

	assign out_valid = stat.out_busy;

`ifndef NO_ASSERTIONS
	// empty flag agrees with length on every shown word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (is_empty == (list_length == '0)))
		else $error("empty flag disagrees with length");
	// never accept while a result is being loaded
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !cmd.out_load)
		else $error("load right after accept");
	// length stays within the pool
	a_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (list_length <= POS_W'(CAPACITY)))
		else $error("length beyond capacity");
`endif
endmodule
`default_nettype wire
